@@ hdl/tcp_timestamp_option_extractor_assert.svh @@
// Assertion macros shared by the timestamp option extractor RTL.
// Depends on nothing; included by tsopt_parser and the top level.
`ifndef TCP_TIMESTAMP_OPTION_EXTRACTOR_ASSERT_SVH
`define TCP_TIMESTAMP_OPTION_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TSOPT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsopt assertion failed");

// next-cycle implication
`define TSOPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsopt assertion failed");

`else

`define TSOPT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TSOPT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/tsopt_pkg.sv @@
// Types and constants for the TCP timestamp option extractor.
// No dependencies; used by the parser and the top level.
package tsopt_pkg;

   // header byte positions within the frame
   localparam logic [7:0] POS_ETYPE_HI = 8'd12;
   localparam logic [7:0] POS_ETYPE_LO = 8'd13;
   localparam logic [7:0] POS_IHL      = 8'd14;
   localparam logic [7:0] POS_PROTO    = 8'd23;

   // fixed sizes and offsets
   localparam logic [8:0] ETH_HDR_LEN      = 9'd14;
   localparam logic [8:0] ETH_IP_MIN_LEN   = 9'd34;
   localparam logic [7:0] TCP_HDR_LEN      = 8'd20;
   localparam logic [7:0] TCP_OFFSET_POS   = 8'd12;
   localparam logic [7:0] TCP_LAST_FIX_POS = 8'd19;
   localparam logic [3:0] IHL_MIN          = 4'd5;
   localparam logic [3:0] TCP_WORDS_MIN    = 4'd5;

   // protocol codes
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  OPT_EOL        = 8'd0;
   localparam logic [7:0]  OPT_NOP        = 8'd1;
   localparam logic [7:0]  OPT_TS         = 8'd8;
   localparam logic [7:0]  OPT_TS_LEN     = 8'd10;
   localparam logic [7:0]  OPT_LEN_MIN    = 8'd2;
   localparam logic [7:0]  TS_DATA_BYTES  = 8'd8;
   localparam logic [7:0]  TS_ECHO_BYTES  = 8'd4;

   localparam logic [15:0] PORT_MATCH_RESET = 16'd8080;

   // option walk phase
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_KIND,
      PH_LEN,
      PH_SKIP,
      PH_STAMP
   } tsopt_phase_type;

   // one verdict per frame
   typedef struct packed {
      logic        verdict;
      logic        record_valid;
      logic [31:0] sender_ts;
      logic [31:0] echo_ts;
   } tsopt_result_type;

endpackage

@@ hdl/tsopt_req_if.sv @@
// Frame byte channel: valid/ready handshake with one byte per beat.
// No dependencies.
interface tsopt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hdl/tsopt_rsp_if.sv @@
// Verdict channel: valid/ready handshake with one frame result per beat.
// No dependencies.
interface tsopt_rsp_if;
   logic        valid;
   logic        ready;
   logic        verdict;
   logic        record_valid;
   logic [31:0] sender_ts;
   logic [31:0] echo_ts;

   modport source (output valid, output verdict, output record_valid,
                   output sender_ts, output echo_ts, input ready);
   modport sink   (input valid, input verdict, input record_valid,
                   input sender_ts, input echo_ts, output ready);
endinterface

@@ hdl/tsopt_parser.sv @@
// Per-frame header and TCP option parser state, one byte per step.
// Depends on tsopt_pkg and tcp_timestamp_option_extractor_assert.svh.
`include "tcp_timestamp_option_extractor_assert.svh"

module tsopt_parser #(
   parameter int MAX_OPTIONS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 data_byte,
   input  logic                       last_byte,
   input  logic [15:0]                port_match,
   output tsopt_pkg::tsopt_result_type result
);

   localparam int SeenWidth = $clog2(MAX_OPTIONS + 1);

   logic [7:0]                 pos_ff, pos_in;
   logic [15:0]                etype_ff, etype_in;
   logic [3:0]                 ihw_ff, ihw_in;
   logic [7:0]                 proto_ff, proto_in;
   logic [15:0]                sport_ff, sport_in;
   logic [15:0]                dport_ff, dport_in;
   logic [3:0]                 thw_ff, thw_in;
   tsopt_pkg::tsopt_phase_type phase_ff, phase_in;
   logic [SeenWidth-1:0]       seen_ff, seen_in;
   logic [7:0]                 kind_ff, kind_in;
   logic [7:0]                 left_ff, left_in;
   logic [31:0]                sender_ff, sender_in;
   logic [31:0]                echo_ff, echo_in;
   logic                       found_ff, found_in;
   logic                       ended_ff, ended_in;

   logic [7:0] tcp_start;
   logic [7:0] tcp_end;
   logic       walk_en;
   logic       port_hit;
   logic       walk_start;
   logic       kind_stop;
   logic       len_stop;
   logic       is_ts;
   logic       ts_fits;
   logic [8:0] frame_len;
   logic [8:0] tcp_min_len;
   logic       rec;

   // tcp header window from the current header lengths
   assign tcp_start = 8'(tsopt_pkg::ETH_HDR_LEN) + {2'b00, ihw_ff, 2'b00};
   assign tcp_end   = tcp_start + {2'b00, thw_ff, 2'b00};
   assign walk_en   = (pos_ff > tsopt_pkg::POS_IHL) && (ihw_ff >= tsopt_pkg::IHL_MIN);

   // option walk decisions
   assign port_hit   = (sport_ff == port_match) || (dport_ff == port_match);
   assign walk_start = (pos_ff == tcp_start + tsopt_pkg::TCP_LAST_FIX_POS) && !ended_ff
                       && (etype_ff == tsopt_pkg::ETHERTYPE_IPV4)
                       && (proto_ff == tsopt_pkg::PROTO_TCP)
                       && port_hit && (thw_ff > tsopt_pkg::TCP_WORDS_MIN);
   assign kind_stop  = (seen_ff >= SeenWidth'(MAX_OPTIONS)) || (pos_ff >= tcp_end)
                       || (data_byte == tsopt_pkg::OPT_EOL);
   assign len_stop   = (pos_ff >= tcp_end) || (data_byte < tsopt_pkg::OPT_LEN_MIN);
   assign is_ts      = (kind_ff == tsopt_pkg::OPT_TS) && (data_byte == tsopt_pkg::OPT_TS_LEN);
   assign ts_fits    = ({1'b0, pos_ff} + 9'd9) <= {1'b0, tcp_end};

   // fixed header fields and tcp ports
   always_comb begin
      pos_in   = (pos_ff == 8'hFF) ? pos_ff : pos_ff + 8'd1;
      etype_in = etype_ff;
      ihw_in   = ihw_ff;
      proto_in = proto_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;
      thw_in   = thw_ff;
      case (pos_ff)
         tsopt_pkg::POS_ETYPE_HI: etype_in[15:8] = data_byte;
         tsopt_pkg::POS_ETYPE_LO: etype_in[7:0]  = data_byte;
         tsopt_pkg::POS_IHL:      ihw_in         = data_byte[3:0];
         tsopt_pkg::POS_PROTO:    proto_in       = data_byte;
         default: ;
      endcase
      if (walk_en) begin
         if (pos_ff == tcp_start) begin
            sport_in[15:8] = data_byte;
         end else if (pos_ff == tcp_start + 8'd1) begin
            sport_in[7:0] = data_byte;
         end else if (pos_ff == tcp_start + 8'd2) begin
            dport_in[15:8] = data_byte;
         end else if (pos_ff == tcp_start + 8'd3) begin
            dport_in[7:0] = data_byte;
         end else if (pos_ff == tcp_start + tsopt_pkg::TCP_OFFSET_POS) begin
            thw_in = data_byte[7:4];
         end
      end
   end

   // walk phase next state
   always_comb begin
      phase_in = phase_ff;
      if (walk_en) begin
         case (phase_ff)
            tsopt_pkg::PH_IDLE: begin
               if (walk_start) phase_in = tsopt_pkg::PH_KIND;
            end
            tsopt_pkg::PH_KIND: begin
               if (kind_stop) begin
                  phase_in = tsopt_pkg::PH_IDLE;
               end else if (data_byte != tsopt_pkg::OPT_NOP) begin
                  phase_in = tsopt_pkg::PH_LEN;
               end
            end
            tsopt_pkg::PH_LEN: begin
               if (len_stop) begin
                  phase_in = tsopt_pkg::PH_IDLE;
               end else if (is_ts) begin
                  phase_in = ts_fits ? tsopt_pkg::PH_STAMP : tsopt_pkg::PH_IDLE;
               end else if (data_byte == tsopt_pkg::OPT_LEN_MIN) begin
                  phase_in = tsopt_pkg::PH_KIND;
               end else begin
                  phase_in = tsopt_pkg::PH_SKIP;
               end
            end
            tsopt_pkg::PH_SKIP: begin
               if (left_ff == 8'd1) phase_in = tsopt_pkg::PH_KIND;
            end
            tsopt_pkg::PH_STAMP: begin
               if (left_ff == 8'd1) phase_in = tsopt_pkg::PH_IDLE;
            end
            default: phase_in = tsopt_pkg::PH_IDLE;
         endcase
      end
   end

   // walk datapath per phase
   always_comb begin
      seen_in   = seen_ff;
      kind_in   = kind_ff;
      left_in   = left_ff;
      sender_in = sender_ff;
      echo_in   = echo_ff;
      found_in  = found_ff;
      ended_in  = ended_ff;
      if (walk_en) begin
         case (phase_ff)
            tsopt_pkg::PH_IDLE: begin
               if (walk_start) seen_in = '0;
            end
            tsopt_pkg::PH_KIND: begin
               if (kind_stop) begin
                  ended_in = 1'b1;
               end else if (data_byte == tsopt_pkg::OPT_NOP) begin
                  seen_in = seen_ff + SeenWidth'(1);
               end else begin
                  kind_in = data_byte;
               end
            end
            tsopt_pkg::PH_LEN: begin
               if (len_stop) begin
                  ended_in = 1'b1;
               end else if (is_ts) begin
                  if (ts_fits) begin
                     left_in = tsopt_pkg::TS_DATA_BYTES;
                  end else begin
                     ended_in = 1'b1;
                  end
               end else begin
                  seen_in = seen_ff + SeenWidth'(1);
                  left_in = data_byte - tsopt_pkg::OPT_LEN_MIN;
               end
            end
            tsopt_pkg::PH_SKIP: begin
               left_in = left_ff - 8'd1;
            end
            tsopt_pkg::PH_STAMP: begin
               if (left_ff > tsopt_pkg::TS_ECHO_BYTES) begin
                  sender_in = {sender_ff[23:0], data_byte};
               end else begin
                  echo_in = {echo_ff[23:0], data_byte};
               end
               left_in = left_ff - 8'd1;
               if (left_ff == 8'd1) begin
                  found_in = 1'b1;
                  ended_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // frame verdict from the state after this byte
   assign frame_len   = {1'b0, pos_ff} + 9'd1;
   assign tcp_min_len = tsopt_pkg::ETH_HDR_LEN + {3'b000, ihw_in, 2'b00}
                        + {1'b0, tsopt_pkg::TCP_HDR_LEN};
   assign rec         = found_in && ((sender_in != '0) || (echo_in != '0));

   always_comb begin
      result              = '0;
      if (frame_len < tsopt_pkg::ETH_HDR_LEN) begin
         result.verdict = 1'b1;
      end else if (etype_in != tsopt_pkg::ETHERTYPE_IPV4) begin
         result.verdict = 1'b0;
      end else if (frame_len < tsopt_pkg::ETH_IP_MIN_LEN) begin
         result.verdict = 1'b1;
      end else if (proto_in != tsopt_pkg::PROTO_TCP) begin
         result.verdict = 1'b0;
      end else if (ihw_in < tsopt_pkg::IHL_MIN) begin
         result.verdict = 1'b0;
      end else if (frame_len < tcp_min_len) begin
         result.verdict = 1'b1;
      end else if (rec) begin
         result.record_valid = 1'b1;
         result.sender_ts    = sender_in;
         result.echo_ts      = echo_in;
      end
   end

   // state registers, cleared after each frame
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         pos_ff    <= '0;
         etype_ff  <= '0;
         ihw_ff    <= '0;
         proto_ff  <= '0;
         sport_ff  <= '0;
         dport_ff  <= '0;
         thw_ff    <= '0;
         phase_ff  <= tsopt_pkg::PH_IDLE;
         seen_ff   <= '0;
         kind_ff   <= '0;
         left_ff   <= '0;
         sender_ff <= '0;
         echo_ff   <= '0;
         found_ff  <= 1'b0;
         ended_ff  <= 1'b0;
      end else if (step) begin
         pos_ff    <= pos_in;
         etype_ff  <= etype_in;
         ihw_ff    <= ihw_in;
         proto_ff  <= proto_in;
         sport_ff  <= sport_in;
         dport_ff  <= dport_in;
         thw_ff    <= thw_in;
         phase_ff  <= phase_in;
         seen_ff   <= seen_in;
         kind_ff   <= kind_in;
         left_ff   <= left_in;
         sender_ff <= sender_in;
         echo_ff   <= echo_in;
         found_ff  <= found_in;
         ended_ff  <= ended_in;
      end
   end

   // walk bookkeeping checks
   `TSOPT_ASSERT_IMPL(a_walk_not_ended, clock, reset, phase_ff != tsopt_pkg::PH_IDLE, !ended_ff)
   `TSOPT_ASSERT_IMPL(a_found_ends_walk, clock, reset, found_ff, ended_ff)
   `TSOPT_ASSERT_IMPL(a_seen_bound, clock, reset, 1'b1, seen_ff <= SeenWidth'(MAX_OPTIONS))

endmodule

@@ hdl/tcp_timestamp_option_extractor.sv @@
// TCP timestamp option extractor, top level.
// Depends on tsopt_pkg, tsopt_req_if, tsopt_rsp_if, tsopt_parser and the assert header.
//
// Frame bytes enter on req_if one per beat in wire order, last_byte set on
// the final byte. Exactly one beat leaves on rsp_if per frame, carrying the
// verdict (0 pass, 1 drop for a truncated header) and, for IPv4 TCP frames
// on the port held in the csr register, the TSval/TSecr pair when a nonzero
// timestamp option was found.
// Each byte is held in an input register and then folded into the parser
// state; the verdict is loaded into the result register at that same edge,
// and rsp_if.valid rises once the result register holds it. One byte is
// accepted every cycle, each making a single parser state update, unless a
// last byte is held back while the result register is full, as below.
// A pending result does not block the next frame's bytes: only a last byte
// waits in the input register while the result register is still full, and
// req_if.ready then drops until rsp_if.ready takes the older verdict.
// Reset clears the parser, both handshake registers and sets the port to
// 8080. csr_wr_en writes csr_wr_data to the port register; write it only
// between frames.
`include "tcp_timestamp_option_extractor_assert.svh"

module tcp_timestamp_option_extractor #(
   parameter int MAX_OPTIONS = 10
) (
   input  logic              clock,
   input  logic              reset,
   tsopt_req_if.sink         req_if,
   tsopt_rsp_if.source       rsp_if,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] port_ff;
   logic        req_take;
   logic        out_free;
   logic        consume;
   logic        load_rsp;

   tsopt_pkg::tsopt_result_type res_ff;
   tsopt_pkg::tsopt_result_type res_next;

   // handshake control
   assign out_free       = !rsp_valid_ff || rsp_if.ready;
   assign consume        = in_valid_ff && (!in_last_ff || out_free);
   assign load_rsp       = consume && in_last_ff;
   assign req_if.ready   = !in_valid_ff || consume;
   assign req_take       = req_if.valid && req_if.ready;
   assign in_valid_in    = req_take || (in_valid_ff && !consume);
   assign rsp_valid_in   = load_rsp || (rsp_valid_ff && !rsp_if.ready);

   // port register
   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff <= tsopt_pkg::PORT_MATCH_RESET;
      end else if (csr_wr_en) begin
         port_ff <= csr_wr_data;
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_if.data_byte;
         in_last_ff <= req_if.last_byte;
      end
   end

   tsopt_parser #(
      .MAX_OPTIONS(MAX_OPTIONS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (consume),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .port_match (port_ff),
      .result     (res_next)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         res_ff <= res_next;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.verdict      = res_ff.verdict;
   assign rsp_if.record_valid = res_ff.record_valid;
   assign rsp_if.sender_ts    = res_ff.sender_ts;
   assign rsp_if.echo_ts      = res_ff.echo_ts;

   // result consistency and stage hand-off
   `TSOPT_ASSERT_IMPL(a_record_passes, clock, reset,
      rsp_valid_ff && res_ff.record_valid, !res_ff.verdict)
   `TSOPT_ASSERT_IMPL(a_no_record_zero, clock, reset,
      rsp_valid_ff && !res_ff.record_valid,
      (res_ff.sender_ts == 32'd0) && (res_ff.echo_ts == 32'd0))
   `TSOPT_ASSERT_NEXT(a_last_loads_rsp, clock, reset, load_rsp, rsp_valid_ff)
   `TSOPT_ASSERT_NEXT(a_held_beat, clock, reset,
      in_valid_ff && !consume, in_valid_ff && $stable(in_byte_ff))

endmodule
